// ----- rtl/core/prq_pkg.sv -----
// prq_pkg: types and constants shared by the priority ready queue
// no dependencies; compiled first

package prq_pkg;

  localparam int TASK_W   = 5;
  localparam int LVL_W    = 3;
  localparam int ID_SPACE = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_PEEK   = 2'd2,
    MODE_MOVE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2
  } status_t;

  typedef struct packed {
    mode_t              mode;
    logic [TASK_W-1:0]  task_id;
    logic [LVL_W-1:0]   task_level;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               head_valid;
    logic [TASK_W-1:0]  head_task;
    logic [LVL_W-1:0]   head_level;
  } out_item_t;

  typedef struct packed {
    logic               v;
    logic [TASK_W-1:0]  task_id;
    logic [LVL_W-1:0]   task_level;
  } cell_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_MARK   = 2'd1,
    CMD_SHIFT  = 2'd2,
    CMD_INSERT = 2'd3
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t            op;
    logic [TASK_W-1:0]  task_id;
    logic [LVL_W-1:0]   task_level;
  } cmd_t;

endpackage

// ----- rtl/core/prq_if.sv -----
// prq_in_if, prq_out_if: valid/ready channels for requests and results
// depends on prq_pkg

interface prq_in_if
  import prq_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface prq_out_if
  import prq_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/prq_cell.sv -----
// prq_cell: one slot of the sorted task chain, trades entries with its neighbours
// depends on prq_pkg

module prq_cell
  import prq_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  cmd_t  cmd,
  input  cell_t left,
  input  cell_t right,
  output cell_t cur
);

  cell_t cell_r;
  cell_t cell_nxt;
  logic  ge_me;
  logic  ge_left;

  assign cur     = cell_r;
  assign ge_me   = cell_r.v && (cell_r.task_level >= cmd.task_level);
  assign ge_left = left.v && (left.task_level >= cmd.task_level);

  always_comb begin
    cell_nxt = cell_r;
    unique case (cmd.op)
      CMD_MARK: begin
        if (cell_r.v && (cell_r.task_id == cmd.task_id)) begin
          cell_nxt.v = 1'b0;
        end
      end
      CMD_SHIFT: begin
        if (!cell_r.v && right.v) begin
          cell_nxt = right;
        end else if (cell_r.v && !left.v) begin
          cell_nxt.v = 1'b0;
        end
      end
      CMD_INSERT: begin
        if (!ge_me) begin
          if (ge_left) begin
            cell_nxt.v          = 1'b1;
            cell_nxt.task_id    = cmd.task_id;
            cell_nxt.task_level = cmd.task_level;
          end else begin
            cell_nxt = left;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.v <= 1'b0;
    end else begin
      cell_r <= cell_nxt;
    end
  end

endmodule

// ----- rtl/core/prq_ctrl.sv -----
// prq_ctrl: request sequencer, queued flags, per-task level store, result register
// depends on prq_pkg and the channel interfaces

module prq_ctrl
  import prq_pkg::*;
#(
  parameter int QDEPTH     = 32,
  parameter int NUM_LEVELS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  prq_in_if.sink     in_chan,
  prq_out_if.source  out_chan,
  input  cell_t      head,
  output cmd_t       cmd
);

  localparam int QIDX_W = $clog2(QDEPTH);
  localparam logic [QIDX_W-1:0] CNT_LAST = QIDX_W'(QDEPTH - 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_SHIFT,
    S_INS,
    S_FIN
  } state_t;

  state_t            state_r;
  in_item_t          req_r;
  logic              qd_r;
  logic [LVL_W-1:0]  lv_rd_r;
  status_t           status_r;
  logic [QIDX_W-1:0] cnt_r;
  logic [QDEPTH-1:0] queued_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [LVL_W-1:0]  lvl_mem [QDEPTH];

  logic [QIDX_W-1:0] idx;
  logic [QIDX_W-1:0] in_idx;
  logic              in_acc;
  logic              out_free;
  logic              in_range;
  logic              found;
  logic              act_ins;
  logic              act_mark;
  logic              ins_now;
  status_t           look_status;

  assign idx      = req_r.task_id[QIDX_W-1:0];
  assign in_idx   = in_chan.payload.task_id[QIDX_W-1:0];
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;
  assign in_range = (32'(req_r.task_id) < QDEPTH) && (32'(req_r.task_level) < NUM_LEVELS);
  assign found    = qd_r && (lv_rd_r == req_r.task_level);

  assign in_chan.ready    = (state_r == S_IDLE);
  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

  always_comb begin
    act_ins     = 1'b0;
    act_mark    = 1'b0;
    look_status = ST_OK;
    if (state_r == S_LOOK) begin
      if ((req_r.mode != MODE_PEEK) && !in_range) begin
        look_status = ST_NOT_FOUND;
      end else begin
        case (req_r.mode)
          MODE_INSERT: begin
            if (qd_r) look_status = ST_DUPLICATE;
            else act_ins = 1'b1;
          end
          MODE_REMOVE: begin
            if (found) act_mark = 1'b1;
            else look_status = ST_NOT_FOUND;
          end
          MODE_MOVE: begin
            if (found) act_mark = 1'b1;
            else if (!qd_r) act_ins = 1'b1;
            else look_status = ST_DUPLICATE;
          end
          default: ;
        endcase
      end
    end
  end

  assign ins_now = act_ins || (state_r == S_INS);

  always_comb begin
    cmd.task_id    = req_r.task_id;
    cmd.task_level = req_r.task_level;
    if (act_mark) begin
      cmd.op = CMD_MARK;
    end else if (ins_now) begin
      cmd.op = CMD_INSERT;
    end else if (state_r == S_SHIFT) begin
      cmd.op = CMD_SHIFT;
    end else begin
      cmd.op = CMD_HOLD;
    end
  end

  // level store, read on accept, written on insert
  always_ff @(posedge clk) begin
    if (ins_now) begin
      lvl_mem[idx] <= req_r.task_level;
    end
    if (in_acc) begin
      lv_rd_r <= lvl_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      queued_r    <= '0;
      cnt_r       <= '0;
    end else begin
      if ((state_r == S_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (ins_now) begin
        queued_r[idx] <= 1'b1;
      end
      if (act_mark) begin
        queued_r[idx] <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_chan.valid) begin
            req_r   <= in_chan.payload;
            qd_r    <= queued_r[in_idx];
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          status_r <= look_status;
          cnt_r    <= '0;
          state_r  <= act_mark ? S_SHIFT : S_FIN;
        end
        S_SHIFT: begin
          if (cnt_r == CNT_LAST) begin
            state_r <= (req_r.mode == MODE_MOVE) ? S_INS : S_FIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_INS: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_item_r.status <= ((req_r.mode == MODE_PEEK) && !head.v) ?
                                 ST_NOT_FOUND : status_r;
            out_item_r.head_valid <= head.v;
            out_item_r.head_task  <= head.v ? head.task_id : '0;
            out_item_r.head_level <= head.v ? head.task_level : '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish state");

  a_shift_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && cnt_r != CNT_LAST) |=> (state_r == S_SHIFT))
    else $error("compaction pass cut short");

  a_ins_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (state_r == S_FIN && queued_r[idx]))
    else $error("queued flag not set after re-insert");
`endif

endmodule

// ----- rtl/core/priority_ready_queue.sv -----
// priority_ready_queue: multilevel ready queue of task ids, top level
// depends on prq_pkg, prq_if, prq_cell and prq_ctrl
//
// in_chan carries one request (mode, task_id, task_level); out_chan returns
// one result per request: status and the head of the highest non-empty level
// after the operation. Both use valid/ready; a transfer happens when both are
// high at a rising edge.
// Tasks live in a row of cells kept sorted by level, highest first and oldest
// first within a level, so the head is always the first cell.
// Insert, peek and rejected requests go from S_LOOK straight to S_FIN; remove
// and move first run the compaction pass that closes the gap left in the cell
// row, one cell per cycle, and move then re-inserts in S_INS (the cell row is
// capped at 32 cells by the task id width).
// One request is in work at a time; the result sits in an output register, so
// a new request is taken while an earlier result is still waiting. If the
// receiver stalls with a result held, the next request waits in its last
// cycle until the output register frees.
// Synchronous reset empties all levels and clears every queued flag.

module priority_ready_queue
  import prq_pkg::*;
#(
  parameter int NUM_TASKS  = 32,
  parameter int NUM_LEVELS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_chan,
  prq_out_if.source out_chan
);

  localparam int QDEPTH = (NUM_TASKS < ID_SPACE) ? NUM_TASKS : ID_SPACE;

  localparam cell_t HEAD_GUARD = '{v: 1'b1, task_id: '0, task_level: '1};
  localparam cell_t TAIL_GUARD = '{v: 1'b0, task_id: '0, task_level: '0};

  cmd_t  cmd;
  cell_t cv [QDEPTH];

  for (genvar i = 0; i < QDEPTH; i++) begin : g_cell
    cell_t lft;
    cell_t rgt;
    if (i == 0) begin : g_first
      assign lft = HEAD_GUARD;
    end else begin : g_left
      assign lft = cv[i-1];
    end
    if (i == QDEPTH - 1) begin : g_last
      assign rgt = TAIL_GUARD;
    end else begin : g_right
      assign rgt = cv[i+1];
    end
    prq_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .cmd   (cmd),
      .left  (lft),
      .right (rgt),
      .cur   (cv[i])
    );
  end

  prq_ctrl #(
    .QDEPTH     (QDEPTH),
    .NUM_LEVELS (NUM_LEVELS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .head     (cv[0]),
    .cmd      (cmd)
  );

`ifndef SYNTHESIS
  for (genvar j = 0; j < QDEPTH - 1; j++) begin : g_chk
    a_compact: assert property (@(posedge clk) disable iff (!rst_n)
      in_chan.ready |-> (cv[j].v || !cv[j+1].v))
      else $error("gap in cell row while idle");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (in_chan.ready && cv[j+1].v) |-> (cv[j].task_level >= cv[j+1].task_level))
      else $error("cell row out of level order while idle");
  end
`endif

endmodule
